// ===== sv/pgs_pkg.sv =====
// ----------------------------------------------------------------------------
// pgs_pkg
// Shared types and constants for the point glide stepper.
// ----------------------------------------------------------------------------
package pgs_pkg;

    localparam int unsigned COORD_W   = 16;
    localparam int unsigned SPEED_W   = 16;
    localparam int unsigned EL_W      = 16;
    localparam int unsigned MAG_W     = 32;
    localparam int unsigned PROD_W    = 48;
    localparam int unsigned DIST_W    = 25;
    localparam int unsigned CNT_W     = 5;

    localparam int unsigned MUL_STEPS  = 16;
    localparam int unsigned SQRT_STEPS = 25;
    localparam int unsigned DIV_STEPS  = 32;

    localparam logic [1:0] KIND_START    = 2'd0;
    localparam logic [1:0] KIND_RETARGET = 2'd1;
    localparam logic [1:0] KIND_TICK     = 2'd2;

    localparam logic [1:0] PH_MOVING  = 2'd0;
    localparam logic [1:0] PH_ARRIVED = 2'd1;
    localparam logic [1:0] PH_IDLE    = 2'd2;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [COORD_W-1:0]  start_x;
        logic signed [COORD_W-1:0]  start_y;
        logic signed [COORD_W-1:0]  target_x;
        logic signed [COORD_W-1:0]  target_y;
        logic [EL_W-1:0]            elapsed;
    } pgs_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic [1:0]                 status;
    } pgs_out_t;

    typedef struct packed {
        logic mul_load;
        logic mul_step;
        logic div_load;
        logic div_step;
    } pgs_axis_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AIM_LOAD,
        ST_SQR,
        ST_SQRT_LOAD,
        ST_SQRT,
        ST_VMUL_LOAD,
        ST_VMUL,
        ST_DIV_LOAD,
        ST_DIV,
        ST_AIM_END,
        ST_TICK_LOAD,
        ST_TMUL,
        ST_TICK_END,
        ST_DONE
    } pgs_state_t;

endpackage

// ===== sv/point_glide_stepper.sv =====
// ----------------------------------------------------------------------------
// point_glide_stepper
// Glides a 2-D point toward a target at constant speed, Q0.32 velocity.
//
//   channel  dir  beat                    handshake
//   s_       in   pgs_in_t (one item)     s_valid / s_ready
//   m_       out  pgs_out_t (one result)  m_valid / m_ready
//   cfg_     in   speed, 16 bits          cfg_valid / cfg_ready (always ready)
//
// Start and retarget run two serial squares, a two-bit-per-cycle square root,
// a serial multiply and a restoring divide, both axes side by side.
// A moving tick runs one serial multiply; other items skip the arithmetic.
// Reset is synchronous; the block comes up idle with speed 0.
// An item is taken while the previous result still waits in the output
// register; a stalled output stalls only the final write-back.
// ----------------------------------------------------------------------------
module point_glide_stepper (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pgs_pkg::pgs_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pgs_pkg::pgs_out_t  m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [pgs_pkg::SPEED_W-1:0] cfg_data
);

    pgs_pkg::pgs_state_t state_reg, state_next;

    logic [pgs_pkg::SPEED_W-1:0]        speed_reg;
    logic signed [pgs_pkg::COORD_W-1:0] cur_x_reg, cur_y_reg, goal_x_reg, goal_y_reg;
    logic [pgs_pkg::MAG_W-1:0]          vel_x_mag_reg, vel_y_mag_reg;
    logic                               vel_x_neg_reg, vel_y_neg_reg;
    logic                               heads_right_reg, heads_down_reg;
    logic [1:0]                         phase_reg, status_reg;
    logic [pgs_pkg::CNT_W-1:0]          cnt_reg;
    logic                               m_valid_reg;
    pgs_pkg::pgs_out_t                  m_data_reg;

    logic [pgs_pkg::COORD_W-1:0]        dxm_reg, dym_reg;
    logic [pgs_pkg::EL_W-1:0]           el_reg;
    logic [49:0]                        sq_v_reg;
    logic [25:0]                        sq_rem_reg;
    logic [pgs_pkg::DIST_W-1:0]         sq_root_reg;

    logic                               accept, out_free, tick_idle, last_step;
    logic signed [pgs_pkg::COORD_W-1:0] base_x, base_y;
    logic signed [pgs_pkg::COORD_W:0]   dx, dy;
    logic [pgs_pkg::COORD_W-1:0]        dxm, dym;

    pgs_pkg::pgs_axis_ctl_t             ctl;
    logic [pgs_pkg::MAG_W-1:0]          mul_a_x, mul_a_y;
    logic [pgs_pkg::SPEED_W-1:0]        mul_b_x, mul_b_y;
    logic [pgs_pkg::PROD_W-1:0]         prod_x, prod_y;
    logic [pgs_pkg::MAG_W-1:0]          quot_x, quot_y;

    logic [32:0]                        d2;
    logic [27:0]                        sq_sh;
    logic [26:0]                        sq_trial;
    logic                               sq_bit;

    logic [pgs_pkg::COORD_W-1:0]        step_x, step_y;
    logic signed [17:0]                 nx, ny, gx, gy;
    logic                               passed;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign tick_idle = (phase_reg != pgs_pkg::PH_MOVING) ||
                       ((cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg));

    assign base_x = (s_data.kind == pgs_pkg::KIND_START) ? s_data.start_x : cur_x_reg;
    assign base_y = (s_data.kind == pgs_pkg::KIND_START) ? s_data.start_y : cur_y_reg;
    assign dx  = {s_data.target_x[15], s_data.target_x} - {base_x[15], base_x};
    assign dy  = {s_data.target_y[15], s_data.target_y} - {base_y[15], base_y};
    assign dxm = dx[16] ? pgs_pkg::COORD_W'(-dx) : dx[15:0];
    assign dym = dy[16] ? pgs_pkg::COORD_W'(-dy) : dy[15:0];

    assign d2       = {1'b0, prod_x[31:0]} + {1'b0, prod_y[31:0]};
    assign sq_sh    = {sq_rem_reg, sq_v_reg[49:48]};
    assign sq_trial = {sq_root_reg, 2'b01};
    assign sq_bit   = (sq_sh >= {1'b0, sq_trial});

    assign step_x = prod_x[47:32];
    assign step_y = prod_y[47:32];
    assign nx = vel_x_neg_reg ? 18'(cur_x_reg) - $signed({2'b00, step_x})
                              : 18'(cur_x_reg) + $signed({2'b00, step_x});
    assign ny = vel_y_neg_reg ? 18'(cur_y_reg) - $signed({2'b00, step_y})
                              : 18'(cur_y_reg) + $signed({2'b00, step_y});
    assign gx = 18'(goal_x_reg);
    assign gy = 18'(goal_y_reg);
    assign passed = ((gx > nx) != heads_right_reg) || ((gy > ny) != heads_down_reg);

    always_comb begin
        unique case (state_reg)
            pgs_pkg::ST_SQR, pgs_pkg::ST_VMUL, pgs_pkg::ST_TMUL:
                last_step = (cnt_reg == pgs_pkg::CNT_W'(pgs_pkg::MUL_STEPS - 1));
            pgs_pkg::ST_SQRT:
                last_step = (cnt_reg == pgs_pkg::CNT_W'(pgs_pkg::SQRT_STEPS - 1));
            pgs_pkg::ST_DIV:
                last_step = (cnt_reg == pgs_pkg::CNT_W'(pgs_pkg::DIV_STEPS - 1));
            default:
                last_step = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pgs_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_data.kind == pgs_pkg::KIND_START ||
                        s_data.kind == pgs_pkg::KIND_RETARGET) begin
                        state_next = pgs_pkg::ST_AIM_LOAD;
                    end else if (s_data.kind == pgs_pkg::KIND_TICK && !tick_idle) begin
                        state_next = pgs_pkg::ST_TICK_LOAD;
                    end else begin
                        state_next = pgs_pkg::ST_DONE;
                    end
                end
            end
            pgs_pkg::ST_AIM_LOAD:  state_next = pgs_pkg::ST_SQR;
            pgs_pkg::ST_SQR:       if (last_step) state_next = pgs_pkg::ST_SQRT_LOAD;
            pgs_pkg::ST_SQRT_LOAD: state_next = pgs_pkg::ST_SQRT;
            pgs_pkg::ST_SQRT:      if (last_step) state_next = pgs_pkg::ST_VMUL_LOAD;
            pgs_pkg::ST_VMUL_LOAD: state_next = pgs_pkg::ST_VMUL;
            pgs_pkg::ST_VMUL:      if (last_step) state_next = pgs_pkg::ST_DIV_LOAD;
            pgs_pkg::ST_DIV_LOAD:  state_next = pgs_pkg::ST_DIV;
            pgs_pkg::ST_DIV:       if (last_step) state_next = pgs_pkg::ST_AIM_END;
            pgs_pkg::ST_AIM_END:   state_next = pgs_pkg::ST_DONE;
            pgs_pkg::ST_TICK_LOAD: state_next = pgs_pkg::ST_TMUL;
            pgs_pkg::ST_TMUL:      if (last_step) state_next = pgs_pkg::ST_TICK_END;
            pgs_pkg::ST_TICK_END:  state_next = pgs_pkg::ST_DONE;
            pgs_pkg::ST_DONE:      if (out_free) state_next = pgs_pkg::ST_IDLE;
            default:               state_next = pgs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == pgs_pkg::ST_IDLE);
        ctl          = '0;
        mul_a_x      = {16'd0, dxm_reg};
        mul_a_y      = {16'd0, dym_reg};
        mul_b_x      = dxm_reg;
        mul_b_y      = dym_reg;
        unique case (state_reg)
            pgs_pkg::ST_AIM_LOAD:  ctl.mul_load = 1'b1;
            pgs_pkg::ST_VMUL_LOAD: begin
                ctl.mul_load = 1'b1;
                mul_b_x      = speed_reg;
                mul_b_y      = speed_reg;
            end
            pgs_pkg::ST_TICK_LOAD: begin
                ctl.mul_load = 1'b1;
                mul_a_x      = vel_x_mag_reg;
                mul_a_y      = vel_y_mag_reg;
                mul_b_x      = el_reg;
                mul_b_y      = el_reg;
            end
            pgs_pkg::ST_SQR, pgs_pkg::ST_VMUL, pgs_pkg::ST_TMUL: ctl.mul_step = 1'b1;
            pgs_pkg::ST_DIV_LOAD:  ctl.div_load = 1'b1;
            pgs_pkg::ST_DIV:       ctl.div_step = 1'b1;
            default:               ctl = '0;
        endcase
    end

    pgs_axis u_axis_x (
        .aclk  (aclk),
        .ctl   (ctl),
        .mul_a (mul_a_x),
        .mul_b (mul_b_x),
        .div_d (sq_root_reg),
        .prod  (prod_x),
        .quot  (quot_x)
    );

    pgs_axis u_axis_y (
        .aclk  (aclk),
        .ctl   (ctl),
        .mul_a (mul_a_y),
        .mul_b (mul_b_y),
        .div_d (sq_root_reg),
        .prod  (prod_y),
        .quot  (quot_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= pgs_pkg::ST_IDLE;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
            speed_reg       <= '0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            goal_x_reg      <= '0;
            goal_y_reg      <= '0;
            vel_x_mag_reg   <= '0;
            vel_y_mag_reg   <= '0;
            vel_x_neg_reg   <= 1'b0;
            vel_y_neg_reg   <= 1'b0;
            heads_right_reg <= 1'b0;
            heads_down_reg  <= 1'b0;
            phase_reg       <= pgs_pkg::PH_IDLE;
            status_reg      <= pgs_pkg::PH_IDLE;
        end else begin
            state_reg <= state_next;

            if (ctl.mul_load || ctl.div_load || state_reg == pgs_pkg::ST_SQRT_LOAD) begin
                cnt_reg <= '0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (cfg_valid) begin
                speed_reg <= cfg_data;
            end

            if (accept) begin
                case (s_data.kind) inside
                    pgs_pkg::KIND_START, pgs_pkg::KIND_RETARGET: begin
                        cur_x_reg       <= base_x;
                        cur_y_reg       <= base_y;
                        goal_x_reg      <= s_data.target_x;
                        goal_y_reg      <= s_data.target_y;
                        heads_right_reg <= !dx[16] && (dxm != '0);
                        heads_down_reg  <= !dy[16] && (dym != '0);
                        vel_x_neg_reg   <= dx[16];
                        vel_y_neg_reg   <= dy[16];
                        phase_reg       <= pgs_pkg::PH_MOVING;
                        status_reg      <= pgs_pkg::PH_MOVING;
                    end
                    pgs_pkg::KIND_TICK: begin
                        if (tick_idle) begin
                            phase_reg  <= pgs_pkg::PH_IDLE;
                            status_reg <= pgs_pkg::PH_IDLE;
                        end
                    end
                    default: status_reg <= phase_reg;
                endcase
            end

            if (state_reg == pgs_pkg::ST_AIM_END) begin
                vel_x_mag_reg <= (sq_root_reg == '0) ? '0 : quot_x;
                vel_y_mag_reg <= (sq_root_reg == '0) ? '0 : quot_y;
            end

            if (state_reg == pgs_pkg::ST_TICK_END) begin
                if (passed) begin
                    cur_x_reg  <= goal_x_reg;
                    cur_y_reg  <= goal_y_reg;
                    phase_reg  <= pgs_pkg::PH_ARRIVED;
                    status_reg <= pgs_pkg::PH_ARRIVED;
                end else begin
                    cur_x_reg  <= nx[15:0];
                    cur_y_reg  <= ny[15:0];
                    status_reg <= pgs_pkg::PH_MOVING;
                end
            end

            if (state_reg == pgs_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dxm_reg <= dxm;
            dym_reg <= dym;
            el_reg  <= s_data.elapsed;
        end

        if (state_reg == pgs_pkg::ST_SQRT_LOAD) begin
            sq_v_reg    <= {1'b0, d2, 16'd0};
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end else if (state_reg == pgs_pkg::ST_SQRT) begin
            sq_v_reg    <= {sq_v_reg[47:0], 2'b00};
            sq_rem_reg  <= sq_bit ? 26'(sq_sh - {1'b0, sq_trial}) : sq_sh[25:0];
            sq_root_reg <= {sq_root_reg[pgs_pkg::DIST_W-2:0], sq_bit};
        end

        if (state_reg == pgs_pkg::ST_DONE && out_free) begin
            m_data_reg.pos_x  <= cur_x_reg;
            m_data_reg.pos_y  <= cur_y_reg;
            m_data_reg.status <= status_reg;
        end
    end

    a_arrived_at_goal: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == pgs_pkg::PH_ARRIVED |->
            (cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg))
        else $error("arrived phase away from goal");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != pgs_pkg::ST_IDLE)
        else $error("item accepted without leaving idle");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pgs_pkg::ST_DONE && out_free) |=> m_valid_reg)
        else $error("finished item did not reach output register");

    a_zero_dist_zero_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pgs_pkg::ST_AIM_END && sq_root_reg == '0) |->
            (dxm_reg == '0) && (dym_reg == '0))
        else $error("zero distance with nonzero delta");

endmodule

// ===== sv/pgs_axis.sv =====
// ----------------------------------------------------------------------------
// pgs_axis
// One axis lane: bit-serial shift-add multiplier and restoring divider.
// The divider takes the product P and forms (P << 24) / divisor, 32 bits.
// ----------------------------------------------------------------------------
module pgs_axis (
    input  logic                          aclk,
    input  pgs_pkg::pgs_axis_ctl_t        ctl,
    input  logic [pgs_pkg::MAG_W-1:0]     mul_a,
    input  logic [pgs_pkg::SPEED_W-1:0]   mul_b,
    input  logic [pgs_pkg::DIST_W-1:0]    div_d,
    output logic [pgs_pkg::PROD_W-1:0]    prod,
    output logic [pgs_pkg::MAG_W-1:0]     quot
);

    logic [pgs_pkg::MAG_W-1:0]   a_reg;
    logic [pgs_pkg::SPEED_W-1:0] b_reg;
    logic [pgs_pkg::PROD_W-1:0]  acc_reg;
    logic [pgs_pkg::DIST_W-1:0]  d_reg;
    logic [pgs_pkg::DIST_W-1:0]  rem_reg;
    logic [pgs_pkg::MAG_W-1:0]   num_reg;
    logic [pgs_pkg::MAG_W-1:0]   quot_reg;
    logic [pgs_pkg::DIST_W:0]    trial;
    logic                        qbit;

    assign trial = {rem_reg, num_reg[pgs_pkg::MAG_W-1]};
    assign qbit  = (trial >= {1'b0, d_reg});

    always_ff @(posedge aclk) begin
        if (ctl.mul_load) begin
            acc_reg <= '0;
            a_reg   <= mul_a;
            b_reg   <= mul_b;
        end else if (ctl.mul_step) begin
            acc_reg <= {acc_reg[pgs_pkg::PROD_W-2:0], 1'b0}
                     + (b_reg[pgs_pkg::SPEED_W-1]
                        ? {{(pgs_pkg::PROD_W-pgs_pkg::MAG_W){1'b0}}, a_reg} : '0);
            b_reg   <= {b_reg[pgs_pkg::SPEED_W-2:0], 1'b0};
        end

        if (ctl.div_load) begin
            rem_reg  <= {1'b0, acc_reg[31:8]};
            num_reg  <= {acc_reg[7:0], 24'd0};
            d_reg    <= div_d;
            quot_reg <= '0;
        end else if (ctl.div_step) begin
            rem_reg  <= qbit ? pgs_pkg::DIST_W'(trial - {1'b0, d_reg})
                             : trial[pgs_pkg::DIST_W-1:0];
            num_reg  <= {num_reg[pgs_pkg::MAG_W-2:0], 1'b0};
            quot_reg <= {quot_reg[pgs_pkg::MAG_W-2:0], qbit};
        end
    end

    assign prod = acc_reg;
    assign quot = quot_reg;

endmodule
